>>> sv/mdb_pkg.sv
// ----------------------------------------------------------------------------
// mdb_pkg
// Shared types, codes and constants of the multi-drop bus master engine.
// ----------------------------------------------------------------------------
package mdb_pkg;

    localparam int MAX_RESPONSE = 64;
    localparam int LEN_W        = 7;
    localparam int TIMER_W      = 16;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QUEUE_AW     = 2;
    localparam int QUEUE_CW     = 3;

    localparam logic [8:0]         MODE_BIT         = 9'h100;
    localparam logic [8:0]         ACK_WORD         = 9'h000;
    localparam logic [7:0]         ACK_BYTE         = 8'h00;
    localparam logic [TIMER_W-1:0] RESP_TIMEOUT_RST = 16'd300;
    localparam logic [TIMER_W-1:0] POLL_TIMEOUT_RST = 16'd50;

    typedef enum logic [1:0] {
        CFG_RESP_TIMEOUT = 2'd0,
        CFG_POLL_TIMEOUT = 2'd1
    } t_cfg_index;

    typedef enum logic [1:0] {
        REQ_CMD  = 2'd0,
        REQ_RX   = 2'd1,
        REQ_TICK = 2'd2
    } t_req_type;

    typedef enum logic [1:0] {
        KIND_TX     = 2'd0,
        KIND_DATA   = 2'd1,
        KIND_STATUS = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ST_ACK     = 3'd0,
        ST_DATA_OK = 3'd1,
        ST_NACK    = 3'd2,
        ST_CHK_ERR = 3'd3,
        ST_TIMEOUT = 3'd4,
        ST_NO_RESP = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_SEND = 3'b010,
        PH_WAIT = 3'b100
    } t_phase;

    typedef struct packed {
        logic [TIMER_W-1:0] resp_timeout;
        logic [TIMER_W-1:0] poll_timeout;
    } t_cfg;

    typedef struct packed {
        logic [1:0]       kind;
        logic [8:0]       word;
        logic [2:0]       status;
        logic [LEN_W-1:0] rx_count;
    } t_result;

    typedef struct packed {
        logic [1:0]        cnt;
        t_result [2:0]     res;
    } t_bundle;

    function automatic t_result mk_result(t_kind kind, logic [8:0] word, t_status status,
                                          logic [LEN_W-1:0] rx_count);
        t_result r;
        r.kind     = kind;
        r.word     = word;
        r.status   = status;
        r.rx_count = rx_count;
        return r;
    endfunction

endpackage

>>> sv/mdb_if.sv
// ----------------------------------------------------------------------------
// mdb_if
// Handshake channels of the engine: request, result and register write.
// ----------------------------------------------------------------------------
interface mdb_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [7:0] cmd_byte;
    logic       cmd_last;
    logic [6:0] expected_length;
    logic       variable_length;
    logic [8:0] rx_word;

    modport source (output valid, req_type, cmd_byte, cmd_last, expected_length,
                    variable_length, rx_word, input ready);
    modport sink   (input valid, req_type, cmd_byte, cmd_last, expected_length,
                    variable_length, rx_word, output ready);
endinterface

interface mdb_res_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [8:0] word;
    logic [2:0] status;
    logic [6:0] rx_count;
    logic       last;

    modport source (output valid, kind, word, status, rx_count, last, input ready);
    modport sink   (input valid, kind, word, status, rx_count, last, output ready);
endinterface

interface mdb_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> sv/mdb_front.sv
// ----------------------------------------------------------------------------
// mdb_front
// Accepts request words, tracks the transaction and builds result bundles.
// ----------------------------------------------------------------------------
module mdb_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    mdb_req_if.sink          i_req,
    input  mdb_pkg::t_cfg    i_cfg,
    input  logic             i_full,
    output logic             o_push,
    output mdb_pkg::t_bundle o_bundle
);
    import mdb_pkg::*;

    t_phase             r_phase,  n_phase;
    logic [7:0]         r_tx_sum, n_tx_sum;
    logic [7:0]         r_sbl,    n_sbl;
    logic [7:0]         r_lrb,    n_lrb;
    logic [LEN_W-1:0]   r_words,  n_words;
    logic [LEN_W-1:0]   r_len,    n_len;
    logic               r_open,   n_open;
    logic [TIMER_W-1:0] r_timer,  n_timer;

    logic               acc;
    t_bundle            bundle;

    assign i_req.ready = !i_full;
    assign acc         = i_req.valid && i_req.ready;
    assign o_bundle    = bundle;
    assign o_push      = acc && (bundle.cnt != 2'd0);

    always_comb begin
        logic             first;
        logic             open_now;
        logic [7:0]       sum;
        logic [LEN_W-1:0] len;
        logic [LEN_W-1:0] wr_inc;
        logic             do_judge;
        logic [LEN_W-1:0] j_words;
        logic [7:0]       j_lrb;
        logic [7:0]       j_sbl;
        logic [1:0]       v_n;

        n_phase  = r_phase;
        n_tx_sum = r_tx_sum;
        n_sbl    = r_sbl;
        n_lrb    = r_lrb;
        n_words  = r_words;
        n_len    = r_len;
        n_open   = r_open;
        n_timer  = r_timer;
        bundle   = '0;
        v_n      = 2'd0;
        do_judge = 1'b0;
        j_words  = r_words;
        j_lrb    = r_lrb;
        j_sbl    = r_sbl;
        first    = (r_phase != PH_SEND);
        open_now = r_open;
        sum      = '0;
        len      = i_req.expected_length;
        wr_inc   = r_words + LEN_W'(1);

        case (i_req.req_type)
            REQ_CMD: begin
                if (r_phase != PH_WAIT) begin
                    if (first) begin
                        if (len == '0) begin
                            len = LEN_W'(1);
                        end else if (len > LEN_W'(MAX_RESPONSE)) begin
                            len = LEN_W'(MAX_RESPONSE);
                        end
                        n_len    = len;
                        n_open   = i_req.variable_length;
                        open_now = i_req.variable_length;
                    end
                    sum      = (first ? 8'h00 : r_tx_sum) + i_req.cmd_byte;
                    n_tx_sum = sum;
                    n_phase  = PH_SEND;
                    bundle.res[v_n] = mk_result(KIND_TX, {first, i_req.cmd_byte},
                                                ST_ACK, '0);
                    v_n = v_n + 2'd1;
                    if (i_req.cmd_last) begin
                        bundle.res[v_n] = mk_result(KIND_TX, {1'b0, sum}, ST_ACK, '0);
                        v_n     = v_n + 2'd1;
                        n_words = '0;
                        n_sbl   = '0;
                        n_lrb   = '0;
                        n_timer = open_now ? i_cfg.poll_timeout : i_cfg.resp_timeout;
                        n_phase = PH_WAIT;
                    end
                end
            end
            REQ_RX: begin
                if (r_phase == PH_WAIT) begin
                    j_sbl   = (r_words != '0) ? (r_sbl + r_lrb) : r_sbl;
                    j_lrb   = i_req.rx_word[7:0];
                    j_words = wr_inc;
                    n_sbl   = j_sbl;
                    n_lrb   = j_lrb;
                    n_words = wr_inc;
                    bundle.res[v_n] = mk_result(KIND_DATA, {1'b0, j_lrb}, ST_ACK, wr_inc);
                    v_n = v_n + 2'd1;
                    do_judge = (wr_inc >= r_len);
                end
            end
            REQ_TICK: begin
                if (r_phase == PH_WAIT) begin
                    if (r_timer > TIMER_W'(1)) begin
                        n_timer = r_timer - TIMER_W'(1);
                    end else begin
                        n_timer = '0;
                        if (!r_open) begin
                            bundle.res[v_n] = mk_result(KIND_STATUS, '0, ST_TIMEOUT, r_words);
                            v_n     = v_n + 2'd1;
                            n_phase = PH_IDLE;
                        end else if (r_words == '0) begin
                            bundle.res[v_n] = mk_result(KIND_STATUS, '0, ST_NO_RESP, '0);
                            v_n     = v_n + 2'd1;
                            n_phase = PH_IDLE;
                        end else begin
                            do_judge = 1'b1;
                        end
                    end
                end
            end
            default: begin
            end
        endcase

        if (do_judge) begin
            if (j_words == LEN_W'(1)) begin
                bundle.res[v_n] = mk_result(KIND_STATUS, '0,
                                            (j_lrb == ACK_BYTE) ? ST_ACK : ST_NACK, j_words);
            end else if (j_sbl == j_lrb) begin
                bundle.res[v_n] = mk_result(KIND_TX, ACK_WORD, ST_ACK, '0);
                v_n = v_n + 2'd1;
                bundle.res[v_n] = mk_result(KIND_STATUS, '0, ST_DATA_OK, j_words);
            end else begin
                bundle.res[v_n] = mk_result(KIND_STATUS, '0, ST_CHK_ERR, j_words);
            end
            v_n     = v_n + 2'd1;
            n_phase = PH_IDLE;
            n_timer = '0;
        end

        bundle.cnt = v_n;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_tx_sum <= '0;
            r_sbl    <= '0;
            r_lrb    <= '0;
            r_words  <= '0;
            r_len    <= LEN_W'(1);
            r_open   <= 1'b0;
            r_timer  <= '0;
        end else if (acc) begin
            r_phase  <= n_phase;
            r_tx_sum <= n_tx_sum;
            r_sbl    <= n_sbl;
            r_lrb    <= n_lrb;
            r_words  <= n_words;
            r_len    <= n_len;
            r_open   <= n_open;
            r_timer  <= n_timer;
        end
    end

    a_wait_below_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_WAIT) |-> (r_words < r_len))
        else $error("response count reached length while still waiting");

    a_last_cmd_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_req.req_type == REQ_CMD && i_req.cmd_last && r_phase != PH_WAIT)
        |=> (r_phase == PH_WAIT))
        else $error("last command byte did not start the response wait");

    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_len != '0) && (r_len <= LEN_W'(MAX_RESPONSE)))
        else $error("response length out of range");

    a_idle_timer_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) |-> (r_timer == '0))
        else $error("wait timer left running outside a transaction");

endmodule

>>> sv/mdb_queue.sv
// ----------------------------------------------------------------------------
// mdb_queue
// Short FIFO of result bundles between the front and back halves.
// ----------------------------------------------------------------------------
module mdb_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  mdb_pkg::t_bundle i_bundle,
    input  logic             i_pop,
    output mdb_pkg::t_bundle o_head,
    output logic             o_empty,
    output logic             o_full
);
    import mdb_pkg::*;

    t_bundle               r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   r_wr_ptr;
    logic [QUEUE_AW-1:0]   r_rd_ptr;
    logic [QUEUE_CW-1:0]   r_count;
    logic                  do_push;
    logic                  do_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == QUEUE_CW'(QUEUE_DEPTH));
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_bundle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + QUEUE_AW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + QUEUE_AW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + QUEUE_CW'(1);
                2'b01:   r_count <= r_count - QUEUE_CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QUEUE_CW'(QUEUE_DEPTH))
        else $error("queue count overflow");

    a_no_lost_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("bundle pushed into a full queue");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wr_ptr - r_rd_ptr) == r_count[QUEUE_AW-1:0])
        else $error("queue pointers disagree with count");

endmodule

>>> sv/mdb_back.sv
// ----------------------------------------------------------------------------
// mdb_back
// Drains result bundles one word at a time and marks the last of each.
// ----------------------------------------------------------------------------
module mdb_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  mdb_pkg::t_bundle i_head,
    input  logic             i_empty,
    output logic             o_pop,
    mdb_res_if.source        o_res
);
    import mdb_pkg::*;

    logic [1:0] r_idx;
    t_result    cur;
    logic       is_last;
    logic       fire;

    assign cur            = i_head.res[r_idx];
    assign is_last        = (r_idx == (i_head.cnt - 2'd1));
    assign o_res.valid    = !i_empty;
    assign o_res.kind     = cur.kind;
    assign o_res.word     = cur.word;
    assign o_res.status   = cur.status;
    assign o_res.rx_count = cur.rx_count;
    assign o_res.last     = is_last;
    assign fire           = o_res.valid && o_res.ready;
    assign o_pop          = fire && is_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (o_pop) begin
            r_idx <= '0;
        end else if (fire) begin
            r_idx <= r_idx + 2'd1;
        end
    end

    a_idx_in_bundle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_empty |-> (r_idx < i_head.cnt))
        else $error("word index past end of bundle");

    a_idx_rewind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_idx == '0))
        else $error("word index not rewound after last word");

    a_idle_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_empty |-> (r_idx == '0))
        else $error("word index moved with no bundle queued");

endmodule

>>> sv/mdb_master_transaction_engine.sv
// ----------------------------------------------------------------------------
// mdb_master_transaction_engine
// Master side of a 9-bit multi-drop bus transaction: command send, checksum,
// response wait with millisecond timeouts, response check and status.
// ----------------------------------------------------------------------------
// Results: the words of an accepted item are queued and offered from the queue head.
// Throughput: 1 request word per cycle while the 4-entry result queue has room;
//   the output drains 1 result word per cycle while the receiver is ready, and
//   an item with k results is offered as k words, the last one marked.
// Reset: synchronous, active low; clears the transaction and the queue and
//   loads the timeout registers with 300 and 50 ms.
module mdb_master_transaction_engine (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mdb_req_if.sink   i_req,
    mdb_cfg_if.sink   i_cfg,
    mdb_res_if.source o_res
);
    import mdb_pkg::*;

    t_cfg    r_cfg;
    logic    full;
    logic    empty;
    logic    push;
    logic    pop;
    t_bundle front_bundle;
    t_bundle head;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.resp_timeout <= RESP_TIMEOUT_RST;
            r_cfg.poll_timeout <= POLL_TIMEOUT_RST;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                CFG_RESP_TIMEOUT: r_cfg.resp_timeout <= i_cfg.data;
                CFG_POLL_TIMEOUT: r_cfg.poll_timeout <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    mdb_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (i_req),
        .i_cfg    (r_cfg),
        .i_full   (full),
        .o_push   (push),
        .o_bundle (front_bundle)
    );

    mdb_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_bundle (front_bundle),
        .i_pop    (pop),
        .o_head   (head),
        .o_empty  (empty),
        .o_full   (full)
    );

    mdb_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .i_empty (empty),
        .o_pop   (pop),
        .o_res   (o_res)
    );

endmodule

>>> test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the multi-drop bus master engine. A directed table
// covers reset behavior, length clamping, ignored requests, ACK and NACK,
// timeouts, poll end with and without data and checksum errors. Random
// transactions follow under several timeout settings, with random gaps on
// both channels and one long receiver stall. Every result word is compared
// with the table entry or an in-bench model of the transaction.
// ----------------------------------------------------------------------------
module testbench;

    import mdb_pkg::*;

    localparam logic [1:0] REQ_UNUSED  = 2'd3;
    localparam logic [1:0] CFG_UNUSED  = 2'd3;
    localparam int         BY_MODEL    = -1;
    localparam int         HOLD_CYCLES = 120;
    localparam int         CYCLE_LIMIT = 400000;
    localparam int         PHASE_ITEMS = 8;

    typedef struct packed {
        logic [1:0] req;
        logic [7:0] cmd_byte;
        logic       cmd_last;
        logic [6:0] exp_len;
        logic       var_len;
        logic [8:0] rx_word;
    } t_req_item;

    typedef struct packed {
        t_kind      kind;
        logic [8:0] word;
        t_status    status;
        logic [6:0] rx_count;
        logic       last;
    } t_expected;

    typedef struct {
        t_req_item item;
        int        reps;
        int        n_exp;
        t_expected e0;
        t_expected e1;
    } t_row;

    localparam t_expected NO_RES = '0;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    mdb_req_if req_ch();
    mdb_cfg_if cfg_ch();
    mdb_res_if res_ch();

    mdb_master_transaction_engine dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .i_cfg   (cfg_ch),
        .o_res   (res_ch)
    );

    // engine model state
    t_phase      ph        = PH_IDLE;
    logic [7:0]  chk_acc   = '0;
    logic [7:0]  rx_sum    = '0;
    logic [7:0]  rx_tail   = '0;
    logic [6:0]  rx_seen   = '0;
    logic [6:0]  rx_target = 7'd1;
    logic        poll_mode = 1'b0;
    logic [15:0] ms_left   = '0;
    logic [15:0] resp_ms   = RESP_TIMEOUT_RST;
    logic [15:0] poll_ms   = POLL_TIMEOUT_RST;

    t_expected   new_results[$];
    t_expected   results_due[$];
    int          failures       = 0;
    int          cycle_count    = 0;
    int          items_taken    = 0;
    bit          no_gaps        = 1'b0;
    int          stall_requests = 0;
    int          stall_served   = 0;
    int          seg_left       = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_expected res(t_kind k, logic [8:0] w, t_status s, logic [6:0] c,
                                      logic lst);
        t_expected e;
        e.kind     = k;
        e.word     = w;
        e.status   = s;
        e.rx_count = c;
        e.last     = lst;
        return e;
    endfunction

    function automatic t_row row(logic [1:0] req, logic [7:0] b, logic lst, logic [6:0] len,
                                 logic vl, logic [8:0] rx, int reps, int n_exp,
                                 t_expected e0, t_expected e1);
        t_row r;
        r.item = '{req: req, cmd_byte: b, cmd_last: lst, exp_len: len, var_len: vl,
                   rx_word: rx};
        r.reps  = reps;
        r.n_exp = n_exp;
        r.e0    = e0;
        r.e1    = e1;
        return r;
    endfunction

    function automatic t_req_item random_item();
        logic [31:0] bits;
        bits = $urandom;
        return bits[$bits(t_req_item)-1:0];
    endfunction

    function automatic void close_response();
        t_status st;
        if (rx_seen == 7'd1) begin
            st = (rx_tail == ACK_BYTE) ? ST_ACK : ST_NACK;
        end else if (rx_sum == rx_tail) begin
            new_results.push_back(res(KIND_TX, ACK_WORD, ST_ACK, 7'd0, 1'b0));
            st = ST_DATA_OK;
        end else begin
            st = ST_CHK_ERR;
        end
        new_results.push_back(res(KIND_STATUS, 9'h000, st, rx_seen, 1'b0));
        ph      = PH_IDLE;
        ms_left = '0;
    endfunction

    // returns 0 when the engine ignores the request
    function automatic bit engine_step(t_req_item it);
        logic [6:0] len;
        new_results.delete();
        case (it.req)
            REQ_CMD: begin
                if (ph == PH_WAIT) return 1'b0;
                if (ph != PH_SEND) begin
                    len = it.exp_len;
                    if (len == 7'd0) len = 7'd1;
                    if (len > MAX_RESPONSE) len = 7'(MAX_RESPONSE);
                    rx_target = len;
                    poll_mode = it.var_len;
                    chk_acc   = '0;
                    ph        = PH_SEND;
                    new_results.push_back(res(KIND_TX, MODE_BIT | {1'b0, it.cmd_byte}, ST_ACK,
                                              7'd0, 1'b0));
                end else begin
                    new_results.push_back(res(KIND_TX, {1'b0, it.cmd_byte}, ST_ACK, 7'd0,
                                              1'b0));
                end
                chk_acc = chk_acc + it.cmd_byte;
                if (it.cmd_last) begin
                    new_results.push_back(res(KIND_TX, {1'b0, chk_acc}, ST_ACK, 7'd0, 1'b0));
                    rx_seen = '0;
                    rx_sum  = '0;
                    rx_tail = '0;
                    ms_left = poll_mode ? poll_ms : resp_ms;
                    ph      = PH_WAIT;
                end
            end
            REQ_RX: begin
                if (ph != PH_WAIT) return 1'b0;
                if (rx_seen != 7'd0) rx_sum = rx_sum + rx_tail;
                rx_tail = it.rx_word[7:0];
                rx_seen = rx_seen + 7'd1;
                new_results.push_back(res(KIND_DATA, {1'b0, rx_tail}, ST_ACK, rx_seen, 1'b0));
                if (rx_seen >= rx_target) close_response();
            end
            REQ_TICK: begin
                if (ph != PH_WAIT) return 1'b0;
                if (ms_left > 16'd1) begin
                    ms_left = ms_left - 16'd1;
                    return 1'b1;
                end
                ms_left = '0;
                if (!poll_mode) begin
                    new_results.push_back(res(KIND_STATUS, 9'h000, ST_TIMEOUT, rx_seen, 1'b0));
                    ph = PH_IDLE;
                end else if (rx_seen == 7'd0) begin
                    new_results.push_back(res(KIND_STATUS, 9'h000, ST_NO_RESP, 7'd0, 1'b0));
                    ph = PH_IDLE;
                end else begin
                    close_response();
                end
            end
            default: return 1'b0;
        endcase
        if (new_results.size() > 0) new_results[new_results.size()-1].last = 1'b1;
        return 1'b1;
    endfunction

    task automatic put_req(input t_req_item it, output bit taken);
        int r;
        int gap;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 60) gap = 0;
        else if (r < 92) gap = $urandom_range(1, 3);
        else gap = $urandom_range(8, 30);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid           <= 1'b1;
        req_ch.req_type        <= it.req;
        req_ch.cmd_byte        <= it.cmd_byte;
        req_ch.cmd_last        <= it.cmd_last;
        req_ch.expected_length <= it.exp_len;
        req_ch.variable_length <= it.var_len;
        req_ch.rx_word         <= it.rx_word;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        taken = engine_step(it);
    endtask

    task automatic send(input t_req_item it);
        bit tk;
        put_req(it, tk);
        foreach (new_results[j]) results_due.push_back(new_results[j]);
        if (tk) items_taken++;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
        req_ch.valid <= 1'b0;
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
        cfg_ch.valid <= 1'b0;
        if (idx == CFG_RESP_TIMEOUT) resp_ms = value;
        else if (idx == CFG_POLL_TIMEOUT) poll_ms = value;
    endtask

    task automatic run_transaction(input bit burst);
        t_req_item   it;
        int          r;
        int          n_cmd;
        int          n_rx;
        logic [6:0]  len;
        logic        vl;
        logic [7:0]  acc;
        logic [7:0]  b;
        logic [15:0] wait_ms;
        bit          good;
        no_gaps = burst || ($urandom_range(0, 3) == 0);
        if (!burst && $urandom_range(0, 4) == 0) begin
            it = random_item();
            r  = $urandom_range(0, 2);
            it.req = (r == 0) ? REQ_RX : (r == 1) ? REQ_TICK : REQ_UNUSED;
            send(it);
        end
        if (burst) begin
            len = 7'd24;
            vl  = 1'b0;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 70) len = 7'($urandom_range(1, 6));
            else if (r < 85) len = 7'($urandom_range(7, 64));
            else if (r < 92) len = 7'd0;
            else len = 7'($urandom_range(65, 127));
            vl = ($urandom_range(0, 2) == 0);
        end
        n_cmd = $urandom_range(1, 4);
        for (int i = 0; i < n_cmd; i++) begin
            it = random_item();
            it.req      = REQ_CMD;
            it.cmd_last = (i == n_cmd - 1);
            if (i == 0) begin
                it.exp_len = len;
                it.var_len = vl;
            end
            send(it);
            if (!burst && i < n_cmd - 1 && $urandom_range(0, 9) == 0) begin
                it = random_item();
                it.req = ($urandom_range(0, 1) != 0) ? REQ_RX : REQ_TICK;
                send(it);
            end
        end
        wait_ms = poll_mode ? poll_ms : resp_ms;
        good    = burst || ($urandom_range(0, 99) < 70);
        if (burst || wait_ms > 16'd40 || $urandom_range(0, 99) < 65) n_rx = rx_target;
        else n_rx = $urandom_range(0, rx_target - 1);
        acc = '0;
        for (int i = 0; i < n_rx && ph == PH_WAIT; i++) begin
            b = 8'($urandom);
            if (good && i == n_rx - 1) b = (n_rx == 1) ? ACK_BYTE : acc;
            acc = acc + b;
            it = random_item();
            it.req     = REQ_RX;
            it.rx_word = {1'($urandom_range(0, 1)), b};
            send(it);
            if (!burst && ph == PH_WAIT && $urandom_range(0, 11) == 0) begin
                it = random_item();
                it.req = ($urandom_range(0, 1) != 0) ? REQ_CMD : REQ_TICK;
                send(it);
            end
        end
        while (ph == PH_WAIT) begin
            it = random_item();
            it.req = REQ_TICK;
            send(it);
        end
    endtask

    function automatic void mismatch(string name, logic [8:0] exp_v, logic [8:0] got_v);
        $error("%s: expected %0h, got %0h", name, exp_v, got_v);
        failures++;
    endfunction

    always @(posedge i_clk) begin
        t_expected e;
        if (i_rst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
            if (results_due.size() == 0) begin
                $error("unexpected result word: kind %0h word %0h", res_ch.kind, res_ch.word);
                failures++;
            end else begin
                e = results_due.pop_front();
                if (res_ch.kind !== e.kind) mismatch("kind", 9'(e.kind), 9'(res_ch.kind));
                if (res_ch.word !== e.word) mismatch("word", e.word, res_ch.word);
                if (res_ch.status !== e.status)
                    mismatch("status", 9'(e.status), 9'(res_ch.status));
                if (res_ch.rx_count !== e.rx_count)
                    mismatch("rx_count", 9'(e.rx_count), 9'(res_ch.rx_count));
                if (res_ch.last !== e.last) mismatch("last", 9'(e.last), 9'(res_ch.last));
            end
        end
    end

    // receiver: random ready segments, long hold on request
    initial res_ch.ready = 1'b0;

    always @(posedge i_clk) begin
        int r;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            seg_left     <= 0;
        end else if (stall_served != stall_requests) begin
            stall_served <= stall_requests;
            res_ch.ready <= 1'b0;
            seg_left     <= HOLD_CYCLES - 1;
        end else if (seg_left > 0) begin
            seg_left <= seg_left - 1;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 20) begin
                res_ch.ready <= 1'b1;
                seg_left     <= $urandom_range(19, 59);
            end else if (r < 70) begin
                res_ch.ready <= 1'b1;
                seg_left     <= $urandom_range(0, 5);
            end else if (r < 93) begin
                res_ch.ready <= 1'b0;
                seg_left     <= $urandom_range(0, 2);
            end else begin
                res_ch.ready <= 1'b0;
                seg_left     <= $urandom_range(9, 29);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[mdb_master_transaction_engine] ERROR");
            $finish;
        end
    end

    initial begin
        t_row        tbl[$];
        bit          tk;
        int          start;
        logic [15:0] r_ms;
        logic [15:0] p_ms;

        req_ch.valid           = 1'b0;
        req_ch.req_type        = REQ_CMD;
        req_ch.cmd_byte        = '0;
        req_ch.cmd_last        = 1'b0;
        req_ch.expected_length = '0;
        req_ch.variable_length = 1'b0;
        req_ch.rx_word         = '0;
        cfg_ch.valid           = 1'b0;
        cfg_ch.index           = CFG_RESP_TIMEOUT;
        cfg_ch.data            = '0;

        tbl.push_back(row(REQ_UNUSED, 8'h5A, 1'b1, 7'd3, 1'b1, 9'h1FF, 1, 0, NO_RES, NO_RES));
        tbl.push_back(row(REQ_RX, 8'h00, 1'b0, 7'd1, 1'b0, 9'h1FF, 1, 0, NO_RES, NO_RES));
        tbl.push_back(row(REQ_TICK, 8'h00, 1'b0, 7'd1, 1'b0, 9'h000, 1, 0, NO_RES, NO_RES));
        tbl.push_back(row(REQ_CMD, 8'hFF, 1'b0, 7'd0, 1'b0, 9'h000, 1, 1,
                          res(KIND_TX, 9'h1FF, ST_ACK, 7'd0, 1'b1), NO_RES));
        tbl.push_back(row(REQ_CMD, 8'h00, 1'b1, 7'd5, 1'b1, 9'h000, 1, 2,
                          res(KIND_TX, 9'h000, ST_ACK, 7'd0, 1'b0),
                          res(KIND_TX, 9'h0FF, ST_ACK, 7'd0, 1'b1)));
        tbl.push_back(row(REQ_CMD, 8'h5A, 1'b1, 7'd2, 1'b0, 9'h000, 1, 0, NO_RES, NO_RES));
        tbl.push_back(row(REQ_RX, 8'h00, 1'b0, 7'd0, 1'b0, 9'h100, 1, 2,
                          res(KIND_DATA, 9'h000, ST_ACK, 7'd1, 1'b0),
                          res(KIND_STATUS, 9'h000, ST_ACK, 7'd1, 1'b1)));
        tbl.push_back(row(REQ_CMD, 8'h30, 1'b1, 7'd1, 1'b0, 9'h000, 1, BY_MODEL,
                          NO_RES, NO_RES));
        tbl.push_back(row(REQ_RX, 8'h00, 1'b0, 7'd0, 1'b0, 9'h0FF, 1, 2,
                          res(KIND_DATA, 9'h0FF, ST_ACK, 7'd1, 1'b0),
                          res(KIND_STATUS, 9'h000, ST_NACK, 7'd1, 1'b1)));
        tbl.push_back(row(REQ_CMD, 8'hAA, 1'b1, 7'd127, 1'b0, 9'h000, 1, BY_MODEL,
                          NO_RES, NO_RES));
        tbl.push_back(row(REQ_RX, 8'h00, 1'b0, 7'd0, 1'b0, 9'h055, 3, BY_MODEL,
                          NO_RES, NO_RES));
        tbl.push_back(row(REQ_TICK, 8'h00, 1'b0, 7'd0, 1'b0, 9'h000, 3, 0, NO_RES, NO_RES));
        tbl.push_back(row(REQ_TICK, 8'h00, 1'b0, 7'd0, 1'b0, 9'h000, 1, 1,
                          res(KIND_STATUS, 9'h000, ST_TIMEOUT, 7'd3, 1'b1), NO_RES));
        tbl.push_back(row(REQ_CMD, 8'h01, 1'b1, 7'd64, 1'b1, 9'h000, 1, BY_MODEL,
                          NO_RES, NO_RES));
        tbl.push_back(row(REQ_TICK, 8'h00, 1'b0, 7'd0, 1'b0, 9'h000, 2, 0, NO_RES, NO_RES));
        tbl.push_back(row(REQ_TICK, 8'h00, 1'b0, 7'd0, 1'b0, 9'h000, 1, 1,
                          res(KIND_STATUS, 9'h000, ST_NO_RESP, 7'd0, 1'b1), NO_RES));
        tbl.push_back(row(REQ_CMD, 8'h80, 1'b0, 7'd10, 1'b1, 9'h000, 1, BY_MODEL,
                          NO_RES, NO_RES));
        tbl.push_back(row(REQ_CMD, 8'h7F, 1'b1, 7'd0, 1'b0, 9'h000, 1, BY_MODEL,
                          NO_RES, NO_RES));
        tbl.push_back(row(REQ_RX, 8'h00, 1'b0, 7'd0, 1'b0, 9'h012, 1, BY_MODEL,
                          NO_RES, NO_RES));
        tbl.push_back(row(REQ_RX, 8'h00, 1'b0, 7'd0, 1'b0, 9'h034, 1, BY_MODEL,
                          NO_RES, NO_RES));
        tbl.push_back(row(REQ_RX, 8'h00, 1'b0, 7'd0, 1'b0, 9'h146, 1, BY_MODEL,
                          NO_RES, NO_RES));
        tbl.push_back(row(REQ_TICK, 8'h00, 1'b0, 7'd0, 1'b0, 9'h000, 3, BY_MODEL,
                          NO_RES, NO_RES));
        tbl.push_back(row(REQ_CMD, 8'h11, 1'b1, 7'd2, 1'b0, 9'h000, 1, BY_MODEL,
                          NO_RES, NO_RES));
        tbl.push_back(row(REQ_RX, 8'h00, 1'b0, 7'd0, 1'b0, 9'h1AB, 1, BY_MODEL,
                          NO_RES, NO_RES));
        tbl.push_back(row(REQ_RX, 8'h00, 1'b0, 7'd0, 1'b0, 9'h000, 1, 2,
                          res(KIND_DATA, 9'h000, ST_ACK, 7'd2, 1'b0),
                          res(KIND_STATUS, 9'h000, ST_CHK_ERR, 7'd2, 1'b1)));
        tbl.push_back(row(REQ_CMD, 8'hC3, 1'b1, 7'd2, 1'b1, 9'h000, 1, BY_MODEL,
                          NO_RES, NO_RES));
        tbl.push_back(row(REQ_RX, 8'h00, 1'b0, 7'd0, 1'b0, 9'h007, 2, BY_MODEL,
                          NO_RES, NO_RES));

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // shorten both waits for the directed timeout rows
        write_reg(CFG_RESP_TIMEOUT, 16'd4);
        write_reg(CFG_POLL_TIMEOUT, 16'd3);

        foreach (tbl[i]) begin
            for (int k = 0; k < tbl[i].reps; k++) begin
                put_req(tbl[i].item, tk);
                if (tbl[i].n_exp == BY_MODEL) begin
                    foreach (new_results[j]) results_due.push_back(new_results[j]);
                end else begin
                    if (tbl[i].n_exp > 0) results_due.push_back(tbl[i].e0);
                    if (tbl[i].n_exp > 1) results_due.push_back(tbl[i].e1);
                end
            end
        end

        for (int p = 0; p < 6; p++) begin
            case (p)
                0: begin
                    r_ms = 16'd1;
                    p_ms = 16'd1;
                end
                1: begin
                    r_ms = 16'd0;
                    p_ms = 16'd0;
                end
                2: begin
                    r_ms = 16'hFFFF;
                    p_ms = 16'hFFFF;
                end
                default: begin
                    r_ms = 16'($urandom_range(1, 12));
                    p_ms = 16'($urandom_range(1, 12));
                end
            endcase
            write_reg(CFG_RESP_TIMEOUT, r_ms);
            write_reg(CFG_POLL_TIMEOUT, p_ms);
            if (p == 2) begin
                write_reg(CFG_UNUSED, 16'($urandom));
                // hold the receiver and push a full transaction back to back
                stall_requests <= stall_requests + 1;
                @(posedge i_clk);
                while (stall_served != stall_requests) @(posedge i_clk);
                run_transaction(1'b1);
            end
            start = items_taken;
            while (items_taken - start < PHASE_ITEMS) run_transaction(1'b0);
        end
        req_ch.valid <= 1'b0;

        while (results_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (failures == 0) begin
            $display("[mdb_master_transaction_engine] OK");
        end else begin
            $display("[mdb_master_transaction_engine] ERROR");
        end
        $finish;
    end

endmodule

>>> sim.f
sv/mdb_pkg.sv
sv/mdb_if.sv
sv/mdb_front.sv
sv/mdb_queue.sv
sv/mdb_back.sv
sv/mdb_master_transaction_engine.sv
test/testbench.sv
